>>> hdl/elmc_pkg.sv
// Package: payload types, engine state layout, command codes and shared helpers.
package elmc_pkg;

  localparam int ENGINE_COUNT_DEF = 3;
  localparam int PRES_MUL = 38174;
  localparam int PRES_OFS = 524288;
  localparam int PRES_SHIFT = 20;
  localparam int PRES_NUM = 200000;
  localparam int PRES_BIAS = 2746789;
  localparam int PRES_DEN = 5493578;
  localparam int SWITCH_COUNT = 4;

  localparam logic [3:0] REQ_THRT = 4'd8;

  localparam int R_STEN = 0;
  localparam int R_START = 1;
  localparam int R_SDEN = 2;
  localparam int R_STDN = 3;
  localparam int R_INLS = 4;
  localparam int R_ENLS = 5;
  localparam int R_LOXD = 6;
  localparam int R_TMSQ = 7;

  localparam int F_PAD = 0;
  localparam int F_FLIGHT = 1;
  localparam int F_CMDF = 2;
  localparam int F_CHAN = 3;
  localparam int F_COMP = 4;
  localparam int F_LIMIT = 5;
  localparam int F_SHUT = 6;
  localparam int F_POST = 7;
  localparam int F_HYD = 8;
  localparam int F_ELEC = 9;
  localparam int F_READY = 10;
  localparam int F_ENISS = 11;

  typedef enum logic [3:0] {
    CMD_IGNT = 4'd0,
    CMD_STDN = 4'd1,
    CMD_SDEN = 4'd2,
    CMD_SVRC = 4'd3,
    CMD_INLS = 4'd4,
    CMD_ENLS = 4'd5,
    CMD_THRT = 4'd6,
    CMD_STEN = 4'd7,
    CMD_LOXD = 4'd8,
    CMD_TMSQ = 4'd9,
    CMD_NONE = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FAIL_LIMIT = 2'd0,
    REG_MIN_POWER  = 2'd1,
    REG_FULL_POWER = 2'd2,
    REG_TIME_TOL   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [0:0]  action;
    logic [1:0]  engine;
    logic [3:0]  request;
    logic [10:0] throttle_pct;
    logic [31:0] expected_time;
    logic [0:0]  on_pad;
    logic [31:0] pri_time;
    logic [15:0] pri_status;
    logic [15:0] pri_pressure;
    logic [31:0] sec_time;
    logic [15:0] sec_status;
    logic [15:0] sec_pressure;
  } item_t;

  typedef struct packed {
    logic [1:0]  engine_out;
    logic [0:0]  command_valid;
    logic [3:0]  command_code;
    logic [10:0] throttle_code;
    logic [11:0] pressure_pct;
    logic [2:0]  phase;
    logic [2:0]  mode;
    logic [11:0] status_flags;
  } result_t;

  typedef struct packed {
    logic [7:0]  fail_limit;
    logic [10:0] min_power;
    logic [10:0] full_power;
    logic [3:0]  time_tol;
  } cfg_t;

  typedef struct packed {
    logic        pri_fail;
    logic        sec_fail;
    logic        switched;
    logic        switch_pend;
    logic [7:0]  fail_count;
    logic [11:0] flags;
    logic [12:0] fields;
    logic [11:0] pressure;
    logic [7:0]  pending;
    cmd_t        last;
  } eng_st_t;

  typedef struct packed {
    logic        pad;
    logic        pri_ok;
    logic        sec_ok;
    logic [15:0] pri_status;
    logic [15:0] sec_status;
    logic [15:0] pri_p;
    logic [15:0] sec_p;
    logic [11:0] pri_q;
    logic [11:0] sec_q;
  } frame_t;

  typedef struct packed {
    logic        valid;
    cmd_t        code;
    logic [10:0] thr;
    logic        thr_taken;
  } issue_t;

  function automatic eng_st_t st_reset();
    eng_st_t s;
    s = '0;
    s.fields = {2'd0, 3'd0, 2'd1, 3'd5, 3'd2};
    s.last = CMD_NONE;
    return s;
  endfunction

  function automatic logic [11:0] pres_coarse(input logic [15:0] p);
    logic [31:0] m;
    m = 32'(p) * 32'(PRES_MUL) + 32'(PRES_OFS);
    return m[31:PRES_SHIFT];
  endfunction

  function automatic logic [11:0] pres_fix(input logic [15:0] p, input logic [11:0] q);
    logic [34:0] lhs;
    logic [34:0] rhs;
    lhs = 35'(p) * 35'(PRES_NUM) + 35'(PRES_BIAS);
    rhs = (35'(q) + 35'd1) * 35'(PRES_DEN);
    return (lhs >= rhs) ? q + 12'd1 : q;
  endfunction

  function automatic logic time_match(input logic [31:0] w, input logic [31:0] x,
                                      input logic [3:0] tol);
    logic [31:0] d;
    d = (w > x) ? w - x : x - w;
    return d < 32'(tol);
  endfunction

endpackage

>>> hdl/elmc_step.sv
// Frame update for one engine: link checks, status decode, flags and command issue.
module elmc_step (
  input  elmc_pkg::eng_st_t cur,
  input  elmc_pkg::frame_t  fr,
  input  elmc_pkg::cfg_t    cfg,
  input  logic              thr_pend,
  input  logic [10:0]       thr_level,
  output elmc_pkg::eng_st_t nst,
  output elmc_pkg::issue_t  iss
);
  import elmc_pkg::*;

  always_comb begin
    eng_st_t s;
    logic [11:0] fl;
    logic dec_pri;
    logic dec_sec;
    logic [15:0] sw;
    logic [2:0] phase;
    logic [2:0] mode;
    logic [1:0] test;
    logic [2:0] chan;
    logic [1:0] cmd;
    s = cur;
    fl = cur.flags;
    fl[F_PAD] = 1'b0;
    dec_pri = 1'b0;
    dec_sec = 1'b0;
    iss = '0;
    iss.code = CMD_IGNT;

    if (!fr.pri_ok) begin
      if (s.pri_fail) fl[F_PAD] = 1'b1;
      else s.pri_fail = 1'b1;
    end else begin
      s.pri_fail = 1'b0;
    end

    if (s.pri_fail || fr.pad) begin
      if (!fr.sec_ok) begin
        if (s.sec_fail) fl[F_PAD] = 1'b1;
        else s.sec_fail = 1'b1;
      end else begin
        s.sec_fail = 1'b0;
      end
      if (s.pri_fail) begin
        if (s.sec_fail) begin
          if (!s.switched) begin
            s.fail_count = s.fail_count + 8'd1;
            if (s.fail_count == 8'(SWITCH_COUNT)) begin
              s.switch_pend = 1'b1;
              s.switched = 1'b1;
              s.fail_count = '0;
            end
          end else if (!fl[F_FLIGHT]) begin
            s.fail_count = s.fail_count + 8'd1;
            if (s.fail_count == cfg.fail_limit) begin
              s.pressure = '0;
              fl[F_FLIGHT] = 1'b1;
            end
          end
        end else begin
          dec_sec = 1'b1;
        end
      end else begin
        dec_pri = 1'b1;
      end
    end else begin
      dec_pri = 1'b1;
    end

    sw = dec_sec ? fr.sec_status : fr.pri_status;
    if (dec_pri || dec_sec) begin
      s.pressure = dec_sec ? pres_fix(fr.sec_p, fr.sec_q) : pres_fix(fr.pri_p, fr.pri_q);
      s.fields = {sw[2:1], sw[5:3], sw[15:14], sw[13:11], sw[10:8]};
    end

    phase = s.fields[2:0];
    mode = s.fields[5:3];
    test = s.fields[7:6];
    chan = s.fields[10:8];
    cmd = s.fields[12:11];
    if (!s.pri_fail || !s.sec_fail) begin
      if (cmd == 2'd1) fl[F_CMDF] = 1'b1;
      if (fr.pad && cmd != 2'd0 && chan != 3'd0) fl[F_CHAN] = 1'b1;
      fl[F_HYD] = 1'b0;
      fl[F_ELEC] = 1'b0;
      fl[F_COMP] = 1'b0;
      fl[F_LIMIT] = 1'b0;
      if (phase == 3'd4) begin
        if (mode == 3'd4) fl[F_HYD] = 1'b1;
        else if (mode == 3'd5) fl[F_ELEC] = 1'b1;
      end else if (phase == 3'd5) begin
        fl[F_SHUT] = 1'b1;
      end else if (phase == 3'd6) begin
        fl[F_SHUT] = 1'b0;
        fl[F_POST] = 1'b1;
      end else if (phase == 3'd2) begin
        fl[F_READY] = (mode == 3'd5);
      end
      if (test == 2'd2) fl[F_COMP] = 1'b1;
      else if (test == 2'd3) fl[F_LIMIT] = 1'b1;
    end

    priority if (s.last == CMD_STEN) begin
      if (s.pending[R_START]) begin
        s.pending[R_START] = 1'b0;
        s.pending[R_STEN] = 1'b0;
        s.last = CMD_IGNT;
        iss.valid = 1'b1;
        iss.code = CMD_IGNT;
      end
    end else if (s.last == CMD_SDEN) begin
      if (s.pending[R_STDN]) begin
        s.pending[R_STDN] = 1'b0;
        fl[F_ENISS] = 1'b0;
        s.last = CMD_STDN;
        iss.valid = 1'b1;
        iss.code = CMD_STDN;
      end
    end else if (s.pending[R_SDEN]) begin
      s.pending[R_SDEN] = 1'b0;
      fl[F_ENISS] = 1'b1;
      s.last = CMD_SDEN;
      iss.valid = 1'b1;
      iss.code = CMD_SDEN;
    end else if (s.switch_pend) begin
      s.switch_pend = 1'b0;
      s.last = CMD_SVRC;
      iss.valid = 1'b1;
      iss.code = CMD_SVRC;
    end else if (s.pending[R_INLS]) begin
      s.pending[R_INLS] = 1'b0;
      s.last = CMD_INLS;
      iss.valid = 1'b1;
      iss.code = CMD_INLS;
    end else if (s.pending[R_ENLS]) begin
      s.pending[R_ENLS] = 1'b0;
      s.last = CMD_ENLS;
      iss.valid = 1'b1;
      iss.code = CMD_ENLS;
    end else if (thr_pend) begin
      iss.thr_taken = 1'b1;
      iss.valid = 1'b1;
      iss.code = CMD_THRT;
      if (thr_level > cfg.min_power) iss.thr = thr_level - cfg.min_power;
    end else if (s.pending[R_STEN]) begin
      s.pending[R_STEN] = 1'b0;
      s.last = CMD_STEN;
      iss.valid = 1'b1;
      iss.code = CMD_STEN;
    end else if (s.pending[R_LOXD]) begin
      s.pending[R_LOXD] = 1'b0;
      s.last = CMD_LOXD;
      iss.valid = 1'b1;
      iss.code = CMD_LOXD;
    end else if (s.pending[R_TMSQ]) begin
      s.pending[R_TMSQ] = 1'b0;
      s.last = CMD_TMSQ;
      iss.valid = 1'b1;
      iss.code = CMD_TMSQ;
    end

    s.flags = fl;
    nst = s;
  end

endmodule

>>> hdl/engine_link_monitor_and_commander.sv
// Top level: engine state memory, read-modify-write stage, result register, config.
//
//  channel   | signals                         | transfer when
//  item      | item_valid item_ready item      | item_valid & item_ready
//  result    | result_valid result_ready result| result_valid & result_ready
//  config    | wr_en wr_index wr_data          | wr_en
//
// One item per cycle while the update stage is not stalled. An item reads its
// engine's entry in the state memory on acceptance, is updated in the update stage
// and written back; a back-to-back item on the same engine takes the written value
// from a bypass register. The result register loads from the update stage for
// frame items only. Reset clears all state at once.
// A held result stalls the update stage only for frame items.
module engine_link_monitor_and_commander #(
  parameter int ENGINE_COUNT = elmc_pkg::ENGINE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  elmc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output elmc_pkg::result_t result,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [10:0]       wr_data
);
  import elmc_pkg::*;

  localparam int IW = (ENGINE_COUNT > 1) ? $clog2(ENGINE_COUNT) : 1;

  cfg_t cfg;
  eng_st_t mem [ENGINE_COUNT];
  logic [ENGINE_COUNT-1:0] mem_ok;
  logic [ENGINE_COUNT-1:0] thr_pend;
  logic [10:0] thr_level;

  eng_st_t rd_st;
  eng_st_t fwd_st;
  logic fwd_hit;
  eng_st_t cur;

  logic s1_valid;
  logic s1_action;
  logic [3:0] s1_req;
  logic [10:0] s1_pct;
  logic [IW-1:0] s1_e;
  frame_t s1_fr;

  logic eng_ok;
  logic useful;
  logic item_fire;
  logic [IW-1:0] addr;
  logic s1_go;
  logic s1_thr;
  logic wr_mem;
  eng_st_t nst;
  eng_st_t req_st;
  eng_st_t wr_st;
  issue_t iss;
  frame_t fr_in;

  assign addr = IW'(item.engine);
  assign eng_ok = int'(item.engine) < ENGINE_COUNT;
  assign useful = item.action[0] ?
                  (item.request == REQ_THRT || (item.request < REQ_THRT && eng_ok)) : eng_ok;
  assign item_fire = item_valid && item_ready;
  assign s1_thr = s1_action && s1_req == REQ_THRT;
  assign s1_go = s1_action || !result_valid || result_ready;
  assign item_ready = !s1_valid || s1_go;
  assign wr_mem = s1_valid && s1_go && !s1_thr;
  assign cur = fwd_hit ? fwd_st : rd_st;

  always_comb begin
    fr_in.pad = item.on_pad[0];
    fr_in.pri_ok = time_match(item.pri_time, item.expected_time, cfg.time_tol);
    fr_in.sec_ok = time_match(item.sec_time, item.expected_time, cfg.time_tol);
    fr_in.pri_status = item.pri_status;
    fr_in.sec_status = item.sec_status;
    fr_in.pri_p = item.pri_pressure;
    fr_in.sec_p = item.sec_pressure;
    fr_in.pri_q = pres_coarse(item.pri_pressure);
    fr_in.sec_q = pres_coarse(item.sec_pressure);
  end

  always_comb begin
    req_st = cur;
    req_st.pending[s1_req[2:0]] = 1'b1;
    wr_st = s1_action ? req_st : nst;
  end

  elmc_step u_step (
    .cur       (cur),
    .fr        (s1_fr),
    .cfg       (cfg),
    .thr_pend  (thr_pend[s1_e]),
    .thr_level (thr_level),
    .nst       (nst),
    .iss       (iss)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fail_limit <= 8'd8;
      cfg.min_power <= 11'd670;
      cfg.full_power <= 11'd1090;
      cfg.time_tol <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_FAIL_LIMIT: cfg.fail_limit <= wr_data[7:0];
        REG_MIN_POWER:  cfg.min_power <= wr_data;
        REG_FULL_POWER: cfg.full_power <= wr_data;
        REG_TIME_TOL:   cfg.time_tol <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_mem) mem[s1_e] <= wr_st;
    if (item_fire && eng_ok) rd_st <= mem_ok[addr] ? mem[addr] : st_reset();
    if (wr_mem) fwd_st <= wr_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ok <= '0;
      thr_pend <= '0;
      thr_level <= '0;
      fwd_hit <= 1'b0;
      s1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (wr_mem) mem_ok[s1_e] <= 1'b1;
      if (item_fire) fwd_hit <= wr_mem && s1_e == addr;
      if (s1_valid && s1_go) begin
        if (s1_thr) begin
          if (s1_pct >= cfg.min_power && s1_pct <= cfg.full_power) begin
            thr_level <= s1_pct;
            thr_pend <= '1;
          end
        end else if (!s1_action && iss.thr_taken) begin
          thr_pend[s1_e] <= 1'b0;
        end
      end
      if (item_fire && useful) s1_valid <= 1'b1;
      else if (s1_go) s1_valid <= 1'b0;
      if (s1_valid && s1_go && !s1_action) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && useful) begin
      s1_action <= item.action[0];
      s1_req <= item.request;
      s1_pct <= item.throttle_pct;
      s1_e <= addr;
      s1_fr <= fr_in;
    end
    if (s1_valid && s1_go && !s1_action) begin
      result.engine_out <= 2'(s1_e);
      result.command_valid <= iss.valid;
      result.command_code <= iss.valid ? iss.code : 4'd0;
      result.throttle_code <= iss.thr;
      result.pressure_pct <= nst.pressure;
      result.phase <= nst.fields[2:0];
      result.mode <= nst.fields[5:3];
      result.status_flags <= nst.flags;
    end
  end

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.command_valid |-> result.command_code == 4'd0 &&
    result.throttle_code == 11'd0) else $error("idle command fields not zero");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid) else $error("update stage lost item");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> item_ready) else $error("empty stage refused item");

endmodule

>>> verif/tb_engine_link_monitor_and_commander.sv
// Testbench for the engine link monitor and commander: directed table plus random items.
module tb_engine_link_monitor_and_commander;
  timeunit 1ns;
  timeprecision 1ps;
  import elmc_pkg::*;

  localparam int NENG = ENGINE_COUNT_DEF;
  localparam int WDOG_LIMIT = 20000;

  // request codes
  localparam logic [3:0] RQ_STEN = 4'd0;
  localparam logic [3:0] RQ_START = 4'd1;
  localparam logic [3:0] RQ_SDEN = 4'd2;
  localparam logic [3:0] RQ_STDN = 4'd3;
  localparam logic [3:0] RQ_INLS = 4'd4;
  localparam logic [3:0] RQ_ENLS = 4'd5;
  localparam logic [3:0] RQ_LOXD = 4'd6;
  localparam logic [3:0] RQ_TMSQ = 4'd7;
  localparam logic [3:0] RQ_THRT = 4'd8;
  localparam logic [0:0] ACT_FRAME = 1'b0;
  localparam logic [0:0] ACT_REQ = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [10:0] wr_data = '0;

  always #5 clk = ~clk;

  engine_link_monitor_and_commander u_dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // predictor state
  logic [7:0] c_limit;
  logic [10:0] c_min, c_full;
  logic [3:0] c_tol;
  logic p_pri[NENG], p_sec[NENG], p_sw[NENG], p_swp[NENG];
  logic [7:0] p_cnt[NENG];
  logic [11:0] p_flags[NENG];
  logic [12:0] p_fields[NENG];
  logic [11:0] p_pres[NENG];
  logic [8:0] p_pend[NENG];
  cmd_t p_last[NENG];
  logic [10:0] p_thr;

  result_t expected_q[$];
  int fails = 0;
  int wdog = 0;
  bit all_sent = 0;

  function automatic bit tmatch(logic [31:0] w, logic [31:0] x);
    logic [31:0] d;
    d = (w > x) ? w - x : x - w;
    return d < {28'd0, c_tol};
  endfunction

  function automatic void decode_word(int e, logic [15:0] s, logic [15:0] p);
    longint unsigned n;
    n = (longint'(p) * 200000 + 2746789) / 5493578;
    p_pres[e] = n[11:0];
    p_fields[e] = {s[2:1], s[5:3], s[15:14], s[13:11], s[10:8]};
  endfunction

  task automatic model_reset();
    c_limit = 8; c_min = 670; c_full = 1090; c_tol = 1; p_thr = 0;
    for (int e = 0; e < NENG; e++) begin
      p_pri[e] = 0; p_sec[e] = 0; p_sw[e] = 0; p_swp[e] = 0; p_cnt[e] = 0;
      p_flags[e] = 0; p_pres[e] = 0; p_pend[e] = 0; p_last[e] = CMD_NONE;
      p_fields[e] = {2'd0, 3'd0, 2'd1, 3'd5, 3'd2};
    end
  endtask

  // returns 1 and fills r when the item yields a result
  function automatic bit predict_engine(item_t it, output result_t r);
    int e;
    logic [11:0] fl;
    logic [2:0] ph, md, ch;
    logic [1:0] ts, cm;
    bit pad, issued;
    cmd_t code;
    r = '0;
    e = it.engine;
    if (it.action == ACT_REQ) begin
      if (it.request == RQ_THRT) begin
        if (it.throttle_pct >= c_min && it.throttle_pct <= c_full) begin
          p_thr = it.throttle_pct;
          for (int k = 0; k < NENG; k++) p_pend[k][8] = 1'b1;
        end
      end else if (it.request < RQ_THRT && e < NENG) p_pend[e][it.request] = 1'b1;
      return 0;
    end
    if (e >= NENG) return 0;
    pad = it.on_pad;
    fl = p_flags[e] & ~12'h001;
    if (!tmatch(it.pri_time, it.expected_time)) begin
      if (p_pri[e]) fl[F_PAD] = 1; else p_pri[e] = 1;
    end else p_pri[e] = 0;
    if (p_pri[e] || pad) begin
      if (!tmatch(it.sec_time, it.expected_time)) begin
        if (p_sec[e]) fl[F_PAD] = 1; else p_sec[e] = 1;
      end else p_sec[e] = 0;
      if (p_pri[e]) begin
        if (p_sec[e]) begin
          if (!p_sw[e]) begin
            p_cnt[e]++;
            if (p_cnt[e] == 4) begin
              p_swp[e] = 1; p_sw[e] = 1; p_cnt[e] = 0;
            end
          end else if (!fl[F_FLIGHT]) begin
            p_cnt[e]++;
            if (p_cnt[e] == c_limit) begin
              p_pres[e] = 0; fl[F_FLIGHT] = 1;
            end
          end
        end else decode_word(e, it.sec_status, it.sec_pressure);
      end else decode_word(e, it.pri_status, it.pri_pressure);
    end else decode_word(e, it.pri_status, it.pri_pressure);
    if (!p_pri[e] || !p_sec[e]) begin
      {cm, ch, ts, md, ph} = p_fields[e];
      if (cm == 1) fl[F_CMDF] = 1;
      if (pad && cm > 0 && ch != 0) fl[F_CHAN] = 1;
      fl[F_HYD] = 0; fl[F_ELEC] = 0; fl[F_COMP] = 0; fl[F_LIMIT] = 0;
      if (ph == 4) begin
        if (md == 4) fl[F_HYD] = 1; else if (md == 5) fl[F_ELEC] = 1;
      end else if (ph == 5) fl[F_SHUT] = 1;
      else if (ph == 6) begin
        fl[F_SHUT] = 0; fl[F_POST] = 1;
      end else if (ph == 2) fl[F_READY] = (md == 5);
      if (ts == 2) fl[F_COMP] = 1; else if (ts == 3) fl[F_LIMIT] = 1;
    end
    p_flags[e] = fl;
    issued = 1; code = CMD_IGNT;
    if (p_last[e] == CMD_STEN) begin
      if (p_pend[e][RQ_START]) begin
        p_pend[e][RQ_START] = 0; p_pend[e][RQ_STEN] = 0; code = CMD_IGNT;
      end else issued = 0;
    end else if (p_last[e] == CMD_SDEN) begin
      if (p_pend[e][RQ_STDN]) begin
        p_pend[e][RQ_STDN] = 0; p_flags[e][F_ENISS] = 0; code = CMD_STDN;
      end else issued = 0;
    end else if (p_pend[e][RQ_SDEN]) begin
      p_pend[e][RQ_SDEN] = 0; p_flags[e][F_ENISS] = 1; code = CMD_SDEN;
    end else if (p_swp[e]) begin
      p_swp[e] = 0; code = CMD_SVRC;
    end else if (p_pend[e][RQ_INLS]) begin
      p_pend[e][RQ_INLS] = 0; code = CMD_INLS;
    end else if (p_pend[e][RQ_ENLS]) begin
      p_pend[e][RQ_ENLS] = 0; code = CMD_ENLS;
    end else if (p_pend[e][8]) begin
      p_pend[e][8] = 0; code = CMD_THRT;
    end else if (p_pend[e][RQ_STEN]) begin
      p_pend[e][RQ_STEN] = 0; code = CMD_STEN;
    end else if (p_pend[e][RQ_LOXD]) begin
      p_pend[e][RQ_LOXD] = 0; code = CMD_LOXD;
    end else if (p_pend[e][RQ_TMSQ]) begin
      p_pend[e][RQ_TMSQ] = 0; code = CMD_TMSQ;
    end else issued = 0;
    if (issued && code != CMD_THRT) p_last[e] = code;
    r.engine_out = e[1:0];
    r.command_valid = issued;
    r.command_code = issued ? code : CMD_IGNT;
    r.throttle_code = (issued && code == CMD_THRT && p_thr > c_min) ? p_thr - c_min : '0;
    r.pressure_pct = p_pres[e];
    r.phase = p_fields[e][2:0];
    r.mode = p_fields[e][5:3];
    r.status_flags = p_flags[e];
    return 1;
  endfunction

  task automatic send_item(item_t it);
    result_t r;
    int gap;
    gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (predict_engine(it, r)) expected_q.push_back(r);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [10:0] val);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_FAIL_LIMIT: c_limit = val[7:0];
      REG_MIN_POWER: c_min = val;
      REG_FULL_POWER: c_full = val;
      default: c_tol = val[3:0];
    endcase
    @(posedge clk);
  endtask

  function automatic item_t rand_item(bit well_formed);
    item_t it;
    logic [31:0] x;
    it = '0;
    it.action = ($urandom_range(0, 2) == 0) ? ACT_REQ : ACT_FRAME;
    it.engine = well_formed ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
    it.request = well_formed ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
    it.throttle_pct = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 2047))
                                                : 11'($urandom_range(c_min, c_full + 5));
    x = $urandom;
    it.expected_time = x;
    it.on_pad = 1'($urandom_range(0, 1));
    it.pri_time = ($urandom_range(0, 2) == 0) ? $urandom : x + $urandom_range(0, 16) - 8;
    it.sec_time = ($urandom_range(0, 2) == 0) ? $urandom : x + $urandom_range(0, 16) - 8;
    it.pri_status = 16'($urandom);
    it.sec_status = 16'($urandom);
    it.pri_pressure = 16'($urandom);
    it.sec_pressure = 16'($urandom);
    return it;
  endfunction

  // directed rows: item, whether a result is typed in, and that result
  typedef struct {
    item_t it;
    bit fixed;
    result_t res;
  } row_t;

  function automatic item_t frame_of(logic [1:0] e, logic [31:0] t, logic [15:0] st,
                                     logic [15:0] pr, bit bad_pri, bit bad_sec);
    item_t it;
    it = '0;
    it.action = ACT_FRAME; it.engine = e; it.expected_time = t;
    it.pri_time = bad_pri ? t + 32'd100 : t; it.sec_time = bad_sec ? ~t : t;
    it.pri_status = st; it.sec_status = ~st; it.pri_pressure = pr; it.sec_pressure = ~pr;
    return it;
  endfunction

  function automatic item_t req_of(logic [1:0] e, logic [3:0] rq, logic [10:0] pct);
    item_t it;
    it = '0;
    it.action = ACT_REQ; it.engine = e; it.request = rq; it.throttle_pct = pct;
    return it;
  endfunction

  row_t rows[$];

  initial begin
    row_t rw;
    result_t r0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // after reset, frame with phase 5 mode 5: shutdown flag only, 0 pressure
    rw.it = frame_of(0, 32'd1000, 16'h6D00, 16'd0, 0, 0);
    rw.fixed = 1;
    rw.res = '{engine_out: 2'd0, command_valid: 1'b0, command_code: 4'd0, throttle_code: 11'd0,
               pressure_pct: 12'd0, phase: 3'd5, mode: 3'd5, status_flags: 12'h040};
    rows.push_back(rw);
    rw.fixed = 0;
    rw.it = frame_of(1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 0); rows.push_back(rw);
    rw.it = frame_of(2, 32'd0, 16'h0000, 16'd2747, 0, 0); rows.push_back(rw);
    for (int q = 0; q < 9; q++) begin
      rw.it = req_of(q % 3, q[3:0], 11'd900); rows.push_back(rw);
    end
    rw.it = req_of(3, RQ_LOXD, 0); rows.push_back(rw);
    rw.it = req_of(0, 4'd15, 11'h7FF); rows.push_back(rw);
    rw.it = req_of(0, RQ_THRT, 11'd2047); rows.push_back(rw);
    for (int q = 0; q < 6; q++) begin
      rw.it = frame_of(0, 32'd5000 + q, 16'h2200, 16'd5000, 1, 1); rows.push_back(rw);
    end
    rw.it = frame_of(3, 32'd5, 16'h1234, 16'd1, 0, 0); rows.push_back(rw);
    rw.it = frame_of(1, 32'd7, 16'h0C3E, 16'd1234, 1, 0); rw.it.on_pad = 1; rows.push_back(rw);
    rw.it = frame_of(2, 32'd9, 16'h8600, 16'd1, 0, 1); rw.it.on_pad = 1; rows.push_back(rw);

    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].fixed && expected_q.size() != 0) begin
        r0 = expected_q[$];
        if (r0 != rows[i].res) begin
          $error("directed row %0d: table %h predictor %h", i, rows[i].res, r0);
          fails++;
        end
      end
    end
    drain();
    write_reg(REG_FAIL_LIMIT, 11'd0);
    write_reg(REG_MIN_POWER, 11'd0);
    write_reg(REG_FULL_POWER, 11'd1200);
    write_reg(REG_TIME_TOL, 11'd15);
    for (int ph = 0; ph < 5; ph++) begin
      for (int n = 0; n < 210; n++) send_item(rand_item($urandom_range(0, 9) != 0));
      drain();
      case (ph)
        0: begin
          write_reg(REG_FAIL_LIMIT, 11'd255); write_reg(REG_TIME_TOL, 11'd0);
          write_reg(REG_MIN_POWER, 11'd1200);
        end
        1: begin
          write_reg(REG_FAIL_LIMIT, 11'd1); write_reg(REG_TIME_TOL, 11'd4);
          write_reg(REG_MIN_POWER, 11'd300); write_reg(REG_FULL_POWER, 11'd0);
        end
        2: begin
          write_reg(REG_FAIL_LIMIT, 11'd5); write_reg(REG_FULL_POWER, 11'd1000);
          write_reg(REG_MIN_POWER, 11'd670);
        end
        default: begin
          write_reg(REG_FAIL_LIMIT, 11'd8); write_reg(REG_TIME_TOL, 11'd1);
          write_reg(REG_MIN_POWER, 11'd800);
        end
      endcase
    end
    all_sent = 1;
  end

  // result side: random stalls, compare with the oldest expectation
  initial begin
    result_t x;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: %h", result);
          fails++;
        end else begin
          x = expected_q.pop_front();
          if (result.engine_out != x.engine_out) begin
            $error("engine_out exp %0d got %0d", x.engine_out, result.engine_out); fails++;
          end
          if (result.command_valid != x.command_valid) begin
            $error("command_valid exp %0d got %0d", x.command_valid, result.command_valid);
            fails++;
          end
          if (result.command_code != x.command_code) begin
            $error("command_code exp %0d got %0d", x.command_code, result.command_code);
            fails++;
          end
          if (result.throttle_code != x.throttle_code) begin
            $error("throttle_code exp %0d got %0d", x.throttle_code, result.throttle_code);
            fails++;
          end
          if (result.pressure_pct != x.pressure_pct) begin
            $error("pressure_pct exp %0d got %0d", x.pressure_pct, result.pressure_pct);
            fails++;
          end
          if (result.phase != x.phase) begin
            $error("phase exp %0d got %0d", x.phase, result.phase); fails++;
          end
          if (result.mode != x.mode) begin
            $error("mode exp %0d got %0d", x.mode, result.mode); fails++;
          end
          if (result.status_flags != x.status_flags) begin
            $error("status_flags exp %h got %h", x.status_flags, result.status_flags);
            fails++;
          end
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else result_ready <= 1'b1;
    end
  end

  // watchdog and end of run
  initial begin
    forever begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("tb_engine_link_monitor_and_commander NOT OK");
        $finish;
      end
      if (all_sent && expected_q.size() == 0) begin
        repeat (10) @(posedge clk);
        if (fails == 0) $display("tb_engine_link_monitor_and_commander OK");
        else $display("tb_engine_link_monitor_and_commander NOT OK");
        $finish;
      end
    end
  end
endmodule

>>> filelist.f
hdl/elmc_pkg.sv
hdl/elmc_step.sv
hdl/engine_link_monitor_and_commander.sv
verif/tb_engine_link_monitor_and_commander.sv
